// ===== hdl/gniw_pkg.sv =====
// Package for the grid neighborhood index walker.
// Holds sizes, register and function codes, the sequencer state type and the
// control bundle shared by the top level and the per-dimension cells.
`default_nettype none

package gniw_pkg;

  // Grid geometry
  localparam int MAX_DIMS   = 4;
  localparam int COORD_BITS = 16;
  localparam int INDEX_BITS = 32;

  // Derived widths
  localparam int OFF_BITS  = COORD_BITS + 1;   // signed offset digit
  localparam int SUM_BITS  = COORD_BITS + 3;   // signed coord/offset arithmetic
  localparam int MAG_BITS  = COORD_BITS + 1;   // magnitude of coord + offset
  localparam int CNT_BITS  = $clog2(INDEX_BITS + MAX_DIMS + 1);
  localparam int SPLIT_LEN = INDEX_BITS + MAX_DIMS;

  // Configuration port
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam int DIM_CNT_BITS  = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_DIM_COUNT = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_DIM0 = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_DIM1 = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_DIM2 = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_DIM3 = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_REACH     = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_WRAP_MODE = 3'd6;

  // Request codes
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_NEXT  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_COMMIT,
    ST_INIT,
    ST_LOAD,
    ST_MOD,
    ST_MAC,
    ST_STEP,
    ST_HOLD
  } gniw_state_t;

  // Broadcast controls and settings seen by every cell
  typedef struct packed {
    logic                  div_clr;
    logic                  mod_load;
    logic                  mod_shift;
    logic                  init_off;
    logic                  wrap;
    logic [COORD_BITS-1:0] reach;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/gniw_cell.sv =====
// One dimension cell of the neighborhood walker chain.
// Holds center coordinate and offset digit, runs a bit-serial divider and
// hands split, carry and index tokens to its neighbors; uses gniw_pkg.
`default_nettype none

module gniw_cell
  import gniw_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cell_ctrl_t            ctrl,
  input  wire logic                  active,
  input  wire logic                  load_coord,
  input  wire logic [COORD_BITS-1:0] size,
  input  wire logic                  split_vld_in,
  input  wire logic                  split_bit_in,
  output logic                       split_vld_out,
  output logic                       split_bit_out,
  input  wire logic                  step_vld_in,
  input  wire logic                  step_carry_in,
  output logic                       step_vld_out,
  output logic                       step_carry_out,
  input  wire logic                  mac_vld_in,
  input  wire logic [INDEX_BITS-1:0] mac_idx_in,
  output logic                       mac_vld_out,
  output logic [INDEX_BITS-1:0]      mac_idx_out
);

  localparam logic signed [SUM_BITS-1:0] SumOne = SUM_BITS'(1);

  logic [COORD_BITS-1:0]        coord_r, coord_nxt;
  logic signed [OFF_BITS-1:0]   off_r, off_nxt;
  logic [COORD_BITS-1:0]        rem_r, rem_nxt;
  logic [MAG_BITS-1:0]          mag_r, mag_nxt;
  logic                         neg_r, neg_nxt;
  logic                         split_vld_r, split_bit_r, split_bit_nxt;
  logic                         step_vld_r, step_carry_r, step_carry_nxt;
  logic                         mac_vld_r;
  logic [INDEX_BITS-1:0]        mac_idx_r, mac_idx_nxt;

  logic signed [SUM_BITS-1:0]   reach_s, coord_s, size_s, off_s, off1_s;
  logic signed [SUM_BITS-1:0]   neg_reach_s, neg_coord_s, init_s, sum_s, abs_s;
  logic signed [OFF_BITS-1:0]   init_off;
  logic                         over, step_act;
  logic                         div_bit, div_en, div_ge;
  logic [COORD_BITS:0]          rem_wide, rem_step;
  logic [COORD_BITS-1:0]        coord_mod;
  logic [INDEX_BITS+COORD_BITS-1:0] prod;

  always_comb begin
    reach_s     = $signed({{(SUM_BITS-COORD_BITS){1'b0}}, ctrl.reach});
    coord_s     = $signed({{(SUM_BITS-COORD_BITS){1'b0}}, coord_r});
    size_s      = $signed({{(SUM_BITS-COORD_BITS){1'b0}}, size});
    off_s       = $signed({{(SUM_BITS-OFF_BITS){off_r[OFF_BITS-1]}}, off_r});
    off1_s      = off_s + SumOne;
    neg_reach_s = -reach_s;
    neg_coord_s = -coord_s;
    // first digit value: wrap runs from -reach, clip stops at the grid edge
    if (ctrl.wrap) begin
      init_s = neg_reach_s;
    end else begin
      init_s = (neg_reach_s > neg_coord_s) ? neg_reach_s : neg_coord_s;
    end
    init_off = $signed(init_s[OFF_BITS-1:0]);
    if (ctrl.wrap) begin
      over = (off1_s > reach_s) || ((off1_s + reach_s) >= size_s);
    end else begin
      over = (off1_s > reach_s) || ((coord_s + off1_s) >= size_s);
    end
    sum_s = coord_s + off_s;
    abs_s = sum_s[SUM_BITS-1] ? -sum_s : sum_s;
  end

  // Restoring divider step, fed by the split stream or the local magnitude
  always_comb begin
    div_bit  = ctrl.mod_shift ? mag_r[MAG_BITS-1] : split_bit_in;
    div_en   = ctrl.mod_shift || (split_vld_in && active);
    rem_wide = {rem_r, div_bit};
    div_ge   = rem_wide >= {1'b0, size};
    rem_step = div_ge ? (rem_wide - {1'b0, size}) : rem_wide;
  end

  always_comb begin
    coord_mod = (neg_r && (rem_r != '0)) ? (size - rem_r) : rem_r;
    prod      = mac_idx_in * size;
  end

  always_comb begin
    rem_nxt = rem_r;
    if (ctrl.div_clr || ctrl.mod_load) begin
      rem_nxt = '0;
    end else if (div_en) begin
      rem_nxt = rem_step[COORD_BITS-1:0];
    end

    split_bit_nxt = active ? div_ge : split_bit_in;

    coord_nxt = load_coord ? rem_r : coord_r;

    mag_nxt = mag_r;
    neg_nxt = neg_r;
    if (ctrl.mod_load) begin
      mag_nxt = abs_s[MAG_BITS-1:0];
      neg_nxt = sum_s[SUM_BITS-1];
    end else if (ctrl.mod_shift) begin
      mag_nxt = {mag_r[MAG_BITS-2:0], 1'b0};
    end

    step_act = step_vld_in && step_carry_in && active;
    off_nxt  = off_r;
    if (ctrl.init_off) begin
      off_nxt = init_off;
    end else if (step_act) begin
      off_nxt = over ? init_off : $signed(off1_s[OFF_BITS-1:0]);
    end
    step_carry_nxt = step_act ? over : step_carry_in;

    mac_idx_nxt = active ? (prod[INDEX_BITS-1:0] + INDEX_BITS'(coord_mod)) : mac_idx_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coord_r      <= '0;
      off_r        <= '0;
      split_vld_r  <= 1'b0;
      step_vld_r   <= 1'b0;
      mac_vld_r    <= 1'b0;
    end else begin
      coord_r      <= coord_nxt;
      off_r        <= off_nxt;
      split_vld_r  <= split_vld_in;
      step_vld_r   <= step_vld_in;
      mac_vld_r    <= mac_vld_in;
    end
  end

  always_ff @(posedge clk) begin
    rem_r        <= rem_nxt;
    mag_r        <= mag_nxt;
    neg_r        <= neg_nxt;
    split_bit_r  <= split_bit_nxt;
    step_carry_r <= step_carry_nxt;
    mac_idx_r    <= mac_idx_nxt;
  end

  assign split_vld_out  = split_vld_r;
  assign split_bit_out  = split_bit_r;
  assign step_vld_out   = step_vld_r;
  assign step_carry_out = step_carry_r;
  assign mac_vld_out    = mac_vld_r;
  assign mac_idx_out    = mac_idx_r;

endmodule

`default_nettype wire

// ===== hdl/grid_neighborhood_index_walker_core.sv =====
// Top level of the grid neighborhood index walker.
// Holds configuration, request sequencer and output register, and chains
// MAX_DIMS gniw_cell instances; uses gniw_pkg.
`default_nettype none

// The walker answers each request with one result: a start request (tuser 0)
// splits the flat center index into per-dimension coordinates and returns the
// first neighbor, or a done result flagged bad if the index is off-grid; a
// next request (tuser 1) returns the following neighbor or done once the
// neighborhood is used up. Requests are handled one at a time. A start
// streams the center index one bit a cycle through the chain of bit-serial
// dividers, then every cell reduces coord + offset by its extent with a
// MAG_BITS-step division, then the flat index is built by a multiply-add that
// moves one cell per cycle. On a next request the odometer carry moves one
// cell per cycle, then the same reduction and multiply-add run. A next request
// with no walk active answers done without running the chain. A finished
// result waits in the output register, so the next request is taken while it
// is still unread.
// Configuration writes are always ready and must only be issued while idle.

module grid_neighborhood_index_walker_core
  import gniw_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // request channel
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  input  wire logic [INDEX_BITS-1:0]    in_tdata,   // [31:0] center_index
  input  wire logic [0:0]               in_tuser,   // [0] func
  // result channel
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  output logic [INDEX_BITS-1:0]         out_tdata,  // [31:0] neighbor_index
  output logic [1:0]                    out_tuser,  // [0] done_res, [1] bad_center
  // configuration writes
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

  // configuration registers
  logic [DIM_CNT_BITS-1:0] dim_count_r;
  logic [COORD_BITS-1:0]   size_r [MAX_DIMS];
  logic [COORD_BITS-1:0]   reach_r;
  logic                    wrap_r;

  // sequencer
  gniw_state_t             state_r, state_nxt;
  logic [CNT_BITS-1:0]     cnt_r, cnt_nxt;
  logic [INDEX_BITS-1:0]   center_sr_r, center_sr_nxt;
  logic                    bad_acc_r, bad_acc_nxt;
  logic                    exhausted_r, exhausted_nxt;
  logic [INDEX_BITS-1:0]   res_idx_r, res_idx_nxt;
  logic                    res_done_r, res_done_nxt;
  logic                    res_bad_r, res_bad_nxt;

  // output register
  logic                    out_valid_r, out_valid_nxt;
  logic [INDEX_BITS-1:0]   out_idx_r;
  logic                    out_done_r, out_bad_r;

  // control outputs of the sequencer
  logic                    in_fire, out_load;
  logic                    split_inject, step_inject, mac_inject;
  logic [MAX_DIMS-1:0]     load_coord;
  cell_ctrl_t              cell_ctrl;

  // chain wiring: split and step run from the top cell down, index up
  logic                    split_vld_w   [MAX_DIMS+1];
  logic                    split_bit_w   [MAX_DIMS+1];
  logic                    step_vld_w    [MAX_DIMS+1];
  logic                    step_carry_w  [MAX_DIMS+1];
  logic                    mac_vld_w     [MAX_DIMS+1];
  logic [INDEX_BITS-1:0]   mac_idx_w     [MAX_DIMS+1];

  logic [DIM_CNT_BITS-1:0] dims_used;
  logic [MAX_DIMS-1:0]     active;
  logic [COORD_BITS-1:0]   extent [MAX_DIMS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_count_r <= DIM_CNT_BITS'(1);
      for (int i = 0; i < MAX_DIMS; i++) begin
        size_r[i] <= COORD_BITS'(1);
      end
      reach_r <= '0;
      wrap_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DIM_COUNT: dim_count_r <= cfg_data[DIM_CNT_BITS-1:0];
        REG_SIZE_DIM0: size_r[0]   <= cfg_data[COORD_BITS-1:0];
        REG_SIZE_DIM1: size_r[1]   <= cfg_data[COORD_BITS-1:0];
        REG_SIZE_DIM2: size_r[2]   <= cfg_data[COORD_BITS-1:0];
        REG_SIZE_DIM3: size_r[3]   <= cfg_data[COORD_BITS-1:0];
        REG_REACH:     reach_r     <= cfg_data[COORD_BITS-1:0];
        REG_WRAP_MODE: wrap_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp dimension count to 1..MAX_DIMS, treat a zero extent as one
  always_comb begin
    if (dim_count_r == '0) begin
      dims_used = DIM_CNT_BITS'(1);
    end else if (dim_count_r > DIM_CNT_BITS'(MAX_DIMS)) begin
      dims_used = DIM_CNT_BITS'(MAX_DIMS);
    end else begin
      dims_used = dim_count_r;
    end
    for (int i = 0; i < MAX_DIMS; i++) begin
      active[i] = DIM_CNT_BITS'(i) < dims_used;
      extent[i] = (size_r[i] == '0) ? COORD_BITS'(1) : size_r[i];
    end
  end

  assign in_fire = in_tvalid && in_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_tuser[0] == FUNC_START) begin
            state_nxt = ST_SPLIT;
          end else if (exhausted_r) begin
            state_nxt = ST_HOLD;
          end else begin
            state_nxt = ST_STEP;
          end
        end
      end
      ST_SPLIT: begin
        if (cnt_r == CNT_BITS'(SPLIT_LEN - 1)) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: state_nxt = bad_acc_r ? ST_HOLD : ST_INIT;
      ST_INIT:   state_nxt = ST_LOAD;
      ST_LOAD:   state_nxt = ST_MOD;
      ST_MOD: begin
        if (cnt_r == CNT_BITS'(MAG_BITS - 1)) begin
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        if (mac_vld_w[MAX_DIMS]) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_STEP: begin
        if (step_vld_w[0]) begin
          state_nxt = step_carry_w[0] ? ST_HOLD : ST_LOAD;
        end
      end
      ST_HOLD: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready           = 1'b0;
    split_inject        = 1'b0;
    step_inject         = 1'b0;
    mac_inject          = 1'b0;
    out_load            = 1'b0;
    load_coord          = '0;
    cell_ctrl.div_clr   = 1'b0;
    cell_ctrl.mod_load  = 1'b0;
    cell_ctrl.mod_shift = 1'b0;
    cell_ctrl.init_off  = 1'b0;
    cell_ctrl.wrap      = wrap_r;
    cell_ctrl.reach     = reach_r;
    case (state_r)
      ST_IDLE: begin
        in_tready         = 1'b1;
        cell_ctrl.div_clr = in_tvalid && (in_tuser[0] == FUNC_START);
        // launch the carry token in the accepting cycle
        step_inject       = in_tvalid && (in_tuser[0] == FUNC_NEXT) && !exhausted_r;
      end
      ST_SPLIT:  split_inject = cnt_r < CNT_BITS'(INDEX_BITS);
      ST_COMMIT: begin
        for (int i = 0; i < MAX_DIMS; i++) begin
          // dimension 0 keeps its old coordinate when the center is rejected
          load_coord[i] = active[i] && ((i != 0) || !bad_acc_r);
        end
      end
      ST_INIT:   cell_ctrl.init_off  = 1'b1;
      ST_LOAD:   cell_ctrl.mod_load  = 1'b1;
      ST_MOD:    cell_ctrl.mod_shift = 1'b1;
      ST_MAC:    mac_inject = (cnt_r == '0);
      ST_STEP:   ;
      ST_HOLD:   out_load = !out_valid_r || out_tready;
      default:   ;
    endcase
  end

  // sequencer datapath
  always_comb begin
    cnt_nxt       = (state_nxt != state_r) ? '0 : cnt_r + CNT_BITS'(1);
    center_sr_nxt = center_sr_r;
    bad_acc_nxt   = bad_acc_r;
    exhausted_nxt = exhausted_r;
    res_idx_nxt   = res_idx_r;
    res_done_nxt  = res_done_r;
    res_bad_nxt   = res_bad_r;

    if (in_fire) begin
      center_sr_nxt = in_tdata;
      bad_acc_nxt   = 1'b0;
      // idle walk: answer done right away
      res_idx_nxt   = '0;
      res_done_nxt  = 1'b1;
      res_bad_nxt   = 1'b0;
    end

    case (state_r)
      ST_SPLIT: begin
        center_sr_nxt = {center_sr_r[INDEX_BITS-2:0], 1'b0};
        // any quotient bit left after dimension 0 means the center is off-grid
        bad_acc_nxt   = bad_acc_r | (split_vld_w[0] & split_bit_w[0]);
      end
      ST_COMMIT: begin
        exhausted_nxt = bad_acc_r;
        res_idx_nxt   = '0;
        res_done_nxt  = 1'b1;
        res_bad_nxt   = 1'b1;
      end
      ST_STEP: begin
        if (step_vld_w[0] && step_carry_w[0]) begin
          exhausted_nxt = 1'b1;
          res_idx_nxt   = '0;
          res_done_nxt  = 1'b1;
          res_bad_nxt   = 1'b0;
        end
      end
      ST_MAC: begin
        if (mac_vld_w[MAX_DIMS]) begin
          res_idx_nxt  = mac_idx_w[MAX_DIMS];
          res_done_nxt = 1'b0;
          res_bad_nxt  = 1'b0;
        end
      end
      default: ;
    endcase

    out_valid_nxt = out_load || (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      exhausted_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      exhausted_r <= exhausted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    center_sr_r <= center_sr_nxt;
    bad_acc_r   <= bad_acc_nxt;
    res_idx_r   <= res_idx_nxt;
    res_done_r  <= res_done_nxt;
    res_bad_r   <= res_bad_nxt;
    if (out_load) begin
      out_idx_r  <= res_idx_r;
      out_done_r <= res_done_r;
      out_bad_r  <= res_bad_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_idx_r;
  assign out_tuser  = {out_bad_r, out_done_r};

  // chain ends
  assign split_vld_w[MAX_DIMS]  = split_inject;
  assign split_bit_w[MAX_DIMS]  = center_sr_r[INDEX_BITS-1];
  assign step_vld_w[MAX_DIMS]   = step_inject;
  assign step_carry_w[MAX_DIMS] = 1'b1;
  assign mac_vld_w[0]           = mac_inject;
  assign mac_idx_w[0]           = '0;

  for (genvar g = 0; g < MAX_DIMS; g++) begin : g_cell
    gniw_cell u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .ctrl           (cell_ctrl),
      .active         (active[g]),
      .load_coord     (load_coord[g]),
      .size           (extent[g]),
      .split_vld_in   (split_vld_w[g+1]),
      .split_bit_in   (split_bit_w[g+1]),
      .split_vld_out  (split_vld_w[g]),
      .split_bit_out  (split_bit_w[g]),
      .step_vld_in    (step_vld_w[g+1]),
      .step_carry_in  (step_carry_w[g+1]),
      .step_vld_out   (step_vld_w[g]),
      .step_carry_out (step_carry_w[g]),
      .mac_vld_in     (mac_vld_w[g]),
      .mac_idx_in     (mac_idx_w[g]),
      .mac_vld_out    (mac_vld_w[g+1]),
      .mac_idx_out    (mac_idx_w[g+1])
    );
  end

`ifndef SYNTHESIS
  a_done_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("done result carries a nonzero index");

  a_bad_is_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0])
    else $error("bad center result not marked done");

  a_split_in_split: assert property (@(posedge clk) disable iff (!rst_n)
    split_vld_w[0] |-> state_r == ST_SPLIT)
    else $error("split stream left the chain outside the split phase");

  a_step_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    step_vld_w[0] |-> state_r == ST_STEP)
    else $error("carry token left the chain outside the step phase");

  a_mac_in_mac: assert property (@(posedge clk) disable iff (!rst_n)
    mac_vld_w[MAX_DIMS] |-> state_r == ST_MAC)
    else $error("index token left the chain outside the index phase");
`endif

endmodule

`default_nettype wire
